### rtl/stack_frame_vm_execute_top_assert.svh
// assertion macros shared by the executor rtl
`ifndef STACK_FRAME_VM_EXECUTE_TOP_ASSERT_SVH
`define STACK_FRAME_VM_EXECUTE_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SFVE_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SFVE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sfve_pkg.sv
// shared types and constants of the frame-stack executor
`default_nettype none

package sfve_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int NUM_REGS_DEF    = 16;
	localparam int FRAME_DEPTH_DEF = 128;

	localparam int PC_W      = 16;
	localparam int VAL_W     = 64;
	localparam int REG_IDX_W = 8;
	localparam int NARG_W    = 8;

	localparam int S_TDATA_W = 120;
	localparam int S_TUSER_W = 5;
	localparam int M_TDATA_W = 88;
	localparam int M_TUSER_W = 2;

	typedef enum logic [3:0] {
		CMD_PUSH      = 4'd0,
		CMD_POP       = 4'd1,
		CMD_REG_TO_TOP = 4'd2,
		CMD_TOP_TO_REG = 4'd3,
		CMD_REG_TO_RET = 4'd4,
		CMD_REG_TO_REG = 4'd5,
		CMD_INPUT     = 4'd6,
		CMD_PRINT     = 4'd7,
		CMD_CALL      = 4'd8,
		CMD_RETURN    = 4'd9,
		CMD_EXIT      = 4'd10,
		CMD_JUMP      = 4'd11
	} cmd_t;

	typedef enum logic [3:0] {
		ERR_OK          = 4'd0,
		ERR_STACK_FULL  = 4'd1,
		ERR_STACK_EMPTY = 4'd2,
		ERR_BAD_REG     = 4'd3,
		ERR_FRAMES_FULL = 4'd4,
		ERR_FEW_ARGS    = 4'd5,
		ERR_UNKNOWN_FN  = 4'd6,
		ERR_BAD_EXIT    = 4'd7,
		ERR_RET_BOTTOM  = 4'd8
	} err_t;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_PRINT = 2'd1,
		KIND_EXIT  = 2'd2
	} kind_t;

	// decoded instruction as it waits in the queue
	typedef struct packed {
		cmd_t                  cmd;
		logic [REG_IDX_W-1:0]  rs;
		logic [REG_IDX_W-1:0]  rd;
		logic [PC_W-1:0]       off;
		logic [PC_W-1:0]       target;
		logic [NARG_W-1:0]     nargs;
		logic                  known;
		logic [VAL_W-1:0]      inval;
		logic                  rs_ok;
		logic                  rd_ok;
	} item_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} qhead_t;

endpackage

`default_nettype wire

### rtl/stack_frame_vm_execute_top.sv
// a queued instruction goes through a registered read of the register, value stack and frame rams
// in ST_RD and then an execute step in ST_EX that registers its result onto the output; the next
// instruction is not read until the current one commits, which waits while the output stalls
// a two-entry queue accepts input while the execute side works or the output stalls, until it is full
// reset: arst_n clears all control state; then a clear pass over max(STACK_DEPTH, NUM_REGS)
// addresses zeroes the register file and value stack while s_tready stays low
`default_nettype none

module stack_frame_vm_execute_top #(
	parameter int STACK_DEPTH = sfve_pkg::STACK_DEPTH_DEF,
	parameter int NUM_REGS    = sfve_pkg::NUM_REGS_DEF,
	parameter int FRAME_DEPTH = sfve_pkg::FRAME_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// [7:0] reg_src, [15:8] reg_dst, [31:16] jump_offset, [47:32] call_target,
	// [55:48] call_arg_count, [119:56] input_value
	input  wire logic [sfve_pkg::S_TDATA_W-1:0] s_tdata,
	// [3:0] cmd, [4] call_target_known
	input  wire logic [sfve_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// [15:0] next_pc, [79:16] out_value, [83:80] error_code, [87:84] zero
	output logic      [sfve_pkg::M_TDATA_W-1:0] m_tdata,
	// [1:0] out_kind
	output logic      [sfve_pkg::M_TUSER_W-1:0] m_tuser
);

	import sfve_pkg::*;

	qhead_t head;
	logic   pop;
	logic   busy;

	sfve_front #(
		.NUM_REGS (NUM_REGS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.busy     (busy),
		.head     (head),
		.pop      (pop)
	);

	sfve_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.NUM_REGS    (NUM_REGS),
		.FRAME_DEPTH (FRAME_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.busy     (busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire

### rtl/sfve_ram.sv
// generic single write port ram with registered read
`default_nettype none

module sfve_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/sfve_front.sv
// input side: unpacks and classifies instructions into a two-entry queue
`default_nettype none

module sfve_front #(
	parameter int NUM_REGS = sfve_pkg::NUM_REGS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// reg_src, reg_dst, jump_offset, call_target, call_arg_count, input_value
	input  wire logic [sfve_pkg::S_TDATA_W-1:0] s_tdata,
	// cmd, call_target_known
	input  wire logic [sfve_pkg::S_TUSER_W-1:0] s_tuser,
	input  wire logic                           busy,
	output sfve_pkg::qhead_t                    head,
	input  wire logic                           pop
);

	import sfve_pkg::*;

	localparam int Q_DEPTH = 2;
	localparam int QP_W    = $clog2(Q_DEPTH);
	localparam int QC_W    = $clog2(Q_DEPTH + 1);

	item_t            in_item;
	item_t            entry_q [Q_DEPTH];
	logic [QP_W-1:0]  wr_ptr_q;
	logic [QP_W-1:0]  rd_ptr_q;
	logic [QC_W-1:0]  cnt_q;
	logic             push;

	always_comb begin
		in_item.cmd    = cmd_t'(s_tuser[3:0]);
		in_item.known  = s_tuser[4];
		in_item.rs     = s_tdata[7:0];
		in_item.rd     = s_tdata[15:8];
		in_item.off    = s_tdata[31:16];
		in_item.target = s_tdata[47:32];
		in_item.nargs  = s_tdata[55:48];
		in_item.inval  = s_tdata[119:56];
		// register range checks are done here, once per instruction
		in_item.rs_ok  = {1'b0, s_tdata[7:0]} < (REG_IDX_W + 1)'(NUM_REGS);
		in_item.rd_ok  = {1'b0, s_tdata[15:8]} < (REG_IDX_W + 1)'(NUM_REGS);
	end

	assign s_tready   = (cnt_q != QC_W'(Q_DEPTH)) && !busy;
	assign push       = s_tvalid && s_tready;
	assign head.valid = (cnt_q != '0);
	assign head.item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`include "stack_frame_vm_execute_top_assert.svh"

	`SFVE_ASSERT_NOW(a_queue_empty_in_clear, clk, arst_n, busy, cnt_q == '0, "queue filled during clear")
	`SFVE_ASSERT_NOW(a_pop_needs_entry, clk, arst_n, pop, cnt_q != '0, "pop from empty queue")
	`SFVE_ASSERT_NOW(a_count_in_range, clk, arst_n, 1'b1, cnt_q <= QC_W'(Q_DEPTH), "queue count above depth")

endmodule

`default_nettype wire

### rtl/sfve_back.sv
// execute side: runs one instruction against registers, value stack and frame store
`default_nettype none

module sfve_back #(
	parameter int STACK_DEPTH = sfve_pkg::STACK_DEPTH_DEF,
	parameter int NUM_REGS    = sfve_pkg::NUM_REGS_DEF,
	parameter int FRAME_DEPTH = sfve_pkg::FRAME_DEPTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire sfve_pkg::qhead_t               head,
	output logic                                pop,
	output logic                                busy,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// next_pc, out_value, error_code, zero pad
	output logic      [sfve_pkg::M_TDATA_W-1:0] m_tdata,
	// out_kind
	output logic      [sfve_pkg::M_TUSER_W-1:0] m_tuser
);

	import sfve_pkg::*;

	localparam int SP_W    = $clog2(STACK_DEPTH);
	localparam int RA_W    = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int FI_W    = $clog2(FRAME_DEPTH);
	localparam int CLR_LEN = (STACK_DEPTH > NUM_REGS) ? STACK_DEPTH : NUM_REGS;
	localparam int CLR_W   = $clog2(CLR_LEN);
	localparam int CW      = ((SP_W > NARG_W) ? SP_W : NARG_W) + 2;
	localparam int FR_W    = PC_W + 2 * SP_W;
	localparam int PAD_W   = M_TDATA_W - PC_W - VAL_W - 4;
	localparam logic [SP_W-1:0] TOP_MAX = SP_W'(STACK_DEPTH - 1);
	localparam logic [FI_W-1:0] FI_MAX  = FI_W'(FRAME_DEPTH - 1);

	typedef enum logic [1:0] {ST_CLR, ST_RD, ST_EX} state_t;

	state_t           state_q;
	logic [CLR_W-1:0] clr_q;
	logic [PC_W-1:0]  pc_q;
	logic [FI_W-1:0]  fi_q;
	logic [SP_W-1:0]  base_q;
	logic [SP_W-1:0]  top_q;
	logic             m_valid_q;
	logic [PC_W-1:0]  m_pc_q;
	kind_t            m_kind_q;
	logic [VAL_W-1:0] m_val_q;
	err_t             m_err_q;

	item_t            it;
	logic             commit;
	logic             has_top;
	logic [PC_W-1:0]  pc_inc;
	logic [SP_W-1:0]  top_m1;
	logic [CW-1:0]    args_end;
	logic [CW-1:0]    callee_base;

	err_t             err;
	kind_t            kind;
	logic [VAL_W-1:0] val;
	logic [PC_W-1:0]  npc;
	logic [SP_W-1:0]  top_n;
	logic [SP_W-1:0]  base_n;
	logic [FI_W-1:0]  fi_n;

	logic             rf_op_we;
	logic [RA_W-1:0]  rf_op_addr;
	logic [VAL_W-1:0] rf_op_data;
	logic             st_op_we;
	logic [SP_W-1:0]  st_op_addr;
	logic [VAL_W-1:0] st_op_data;
	logic             fr_op_we;

	logic             rf_we;
	logic [RA_W-1:0]  rf_waddr;
	logic [VAL_W-1:0] rf_wdata;
	logic [VAL_W-1:0] rf_rdata;
	logic             st_we;
	logic [SP_W-1:0]  st_waddr;
	logic [VAL_W-1:0] st_wdata;
	logic [SP_W-1:0]  st_raddr;
	logic [VAL_W-1:0] st_rdata;
	logic [FR_W-1:0]  fr_rdata;
	logic             rd_en;

	assign it       = head.item;
	assign busy     = (state_q == ST_CLR);
	assign commit   = (state_q == ST_EX) && (!m_valid_q || m_tready);
	assign pop      = commit;
	assign rd_en    = (state_q == ST_RD);
	assign has_top  = top_q > base_q;
	assign pc_inc   = pc_q + 1'b1;
	assign top_m1   = top_q - 1'b1;
	assign args_end = CW'(base_q) + CW'(1) + CW'(it.nargs);
	assign callee_base = CW'(top_q) - CW'(1) - CW'(it.nargs);

	// exit always reads the stack bottom, everything else the current top
	assign st_raddr = (it.cmd == CMD_EXIT) ? '0 : top_m1;

	always_comb begin
		err        = ERR_OK;
		kind       = KIND_NONE;
		val        = '0;
		npc        = pc_inc;
		top_n      = top_q;
		base_n     = base_q;
		fi_n       = fi_q;
		rf_op_we   = 1'b0;
		rf_op_addr = RA_W'(it.rs);
		rf_op_data = it.inval;
		st_op_we   = 1'b0;
		st_op_addr = top_m1;
		st_op_data = rf_rdata;
		fr_op_we   = 1'b0;
		case (it.cmd)
			CMD_PUSH: begin
				if (top_q >= TOP_MAX) err = ERR_STACK_FULL;
				else top_n = top_q + 1'b1;
			end
			CMD_POP: begin
				if (!has_top) err = ERR_STACK_EMPTY;
				else top_n = top_m1;
			end
			CMD_REG_TO_TOP: begin
				if (!it.rs_ok) err = ERR_BAD_REG;
				else if (!has_top) err = ERR_STACK_EMPTY;
				else st_op_we = 1'b1;
			end
			CMD_TOP_TO_REG: begin
				rf_op_data = st_rdata;
				if (!it.rs_ok) err = ERR_BAD_REG;
				else if (!has_top) err = ERR_STACK_EMPTY;
				else rf_op_we = 1'b1;
			end
			CMD_REG_TO_RET: begin
				st_op_addr = base_q;
				if (!it.rs_ok) err = ERR_BAD_REG;
				else st_op_we = 1'b1;
			end
			CMD_REG_TO_REG: begin
				rf_op_addr = RA_W'(it.rd);
				rf_op_data = rf_rdata;
				if (!it.rs_ok || !it.rd_ok) err = ERR_BAD_REG;
				else rf_op_we = 1'b1;
			end
			CMD_INPUT: begin
				if (!it.rs_ok) err = ERR_BAD_REG;
				else rf_op_we = 1'b1;
			end
			CMD_PRINT: begin
				if (!it.rs_ok) err = ERR_BAD_REG;
				else begin
					kind = KIND_PRINT;
					val  = rf_rdata;
				end
			end
			CMD_CALL: begin
				if (!it.known) err = ERR_UNKNOWN_FN;
				else if (fi_q >= FI_MAX) err = ERR_FRAMES_FULL;
				else if (args_end > CW'(top_q)) err = ERR_FEW_ARGS;
				else begin
					// caller frame is saved; callee starts with the caller's top
					fr_op_we = 1'b1;
					fi_n     = fi_q + 1'b1;
					base_n   = callee_base[SP_W-1:0];
					npc      = it.target;
				end
			end
			CMD_RETURN: begin
				if (base_q >= TOP_MAX) err = ERR_STACK_FULL;
				else if (fi_q == '0) err = ERR_RET_BOTTOM;
				else begin
					fi_n   = fi_q - 1'b1;
					npc    = fr_rdata[FR_W-1 -: PC_W];
					base_n = fr_rdata[2*SP_W-1 -: SP_W];
					top_n  = fr_rdata[SP_W-1:0];
				end
			end
			CMD_EXIT: begin
				if (fi_q != '0 || top_q != SP_W'(1)) err = ERR_BAD_EXIT;
				else begin
					kind = KIND_EXIT;
					val  = st_rdata;
					npc  = pc_q;
				end
			end
			CMD_JUMP: begin
				npc = pc_q + it.off;
			end
			default: begin
			end
		endcase
		if (err != ERR_OK) begin
			npc  = pc_q;
			kind = KIND_NONE;
			val  = '0;
		end
	end

	// clear pass owns the register file and value stack write ports right after reset
	always_comb begin
		if (state_q == ST_CLR) begin
			rf_we    = ({1'b0, clr_q} < (CLR_W + 1)'(NUM_REGS));
			rf_waddr = RA_W'(clr_q);
			rf_wdata = '0;
			st_we    = ({1'b0, clr_q} < (CLR_W + 1)'(STACK_DEPTH));
			st_waddr = SP_W'(clr_q);
			st_wdata = '0;
		end else begin
			rf_we    = commit && rf_op_we;
			rf_waddr = rf_op_addr;
			rf_wdata = rf_op_data;
			st_we    = commit && st_op_we;
			st_waddr = st_op_addr;
			st_wdata = st_op_data;
		end
	end

	sfve_ram #(
		.WIDTH (VAL_W),
		.DEPTH (NUM_REGS)
	) u_regs (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rf_waddr),
		.wdata (rf_wdata),
		.re    (rd_en),
		.raddr (RA_W'(it.rs)),
		.rdata (rf_rdata)
	);

	sfve_ram #(
		.WIDTH (VAL_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (rd_en),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// saved caller frames: return pc, base, top
	sfve_ram #(
		.WIDTH (FR_W),
		.DEPTH (FRAME_DEPTH)
	) u_frames (
		.clk   (clk),
		.we    (commit && fr_op_we),
		.waddr (fi_q),
		.wdata ({pc_inc, base_q, top_q}),
		.re    (rd_en),
		.raddr (fi_q - 1'b1),
		.rdata (fr_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			pc_q      <= '0;
			fi_q      <= '0;
			base_q    <= '0;
			top_q     <= '0;
			m_valid_q <= 1'b0;
			m_pc_q    <= '0;
			m_kind_q  <= KIND_NONE;
			m_val_q   <= '0;
			m_err_q   <= ERR_OK;
		end else begin
			if (commit) begin
				m_valid_q <= 1'b1;
				m_pc_q    <= npc;
				m_kind_q  <= kind;
				m_val_q   <= val;
				m_err_q   <= err;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_LEN - 1)) state_q <= ST_RD;
				end
				ST_RD: begin
					if (head.valid) state_q <= ST_EX;
				end
				ST_EX: begin
					if (commit) begin
						state_q <= ST_RD;
						pc_q    <= npc;
						fi_q    <= fi_n;
						base_q  <= base_n;
						top_q   <= top_n;
					end
				end
				default: state_q <= ST_CLR;
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, m_err_q, m_val_q, m_pc_q};
	assign m_tuser  = m_kind_q;

`include "stack_frame_vm_execute_top_assert.svh"

	`SFVE_ASSERT_NOW(a_top_not_below_base, clk, arst_n, 1'b1, top_q >= base_q, "frame top below base")
	`SFVE_ASSERT_NOW(a_frame_in_range, clk, arst_n, 1'b1, fi_q <= FI_MAX, "frame index out of range")
	`SFVE_ASSERT_NEXT(a_error_holds_pc, clk, arst_n, commit && (err != ERR_OK), $stable(pc_q), "pc moved on error")
	`SFVE_ASSERT_NOW(a_exec_has_item, clk, arst_n, state_q == ST_EX, head.valid, "execute without queued item")

endmodule

`default_nettype wire
